[sv/mexp_pkg.sv]
`default_nettype none

package mexp_pkg;

  localparam int DEFAULT_WIDTH    = 32;
  localparam int DEFAULT_EXPONENT = 359;

  localparam int REG_INDEX_WIDTH = 1;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_EXPONENT = 1'd0;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_MODULUS  = 1'd1;

  typedef struct packed {
    logic busy;
    logic done;
  } mm_status_t;

endpackage

`default_nettype wire

[sv/mexp_if.sv]
`default_nettype none

interface mexp_in_if #(
  parameter int WIDTH = mexp_pkg::DEFAULT_WIDTH
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] base;

  modport source (output valid, output base, input ready);
  modport sink (input valid, input base, output ready);
endinterface

interface mexp_out_if #(
  parameter int WIDTH = mexp_pkg::DEFAULT_WIDTH
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] power_mod;

  modport source (output valid, output power_mod, input ready);
  modport sink (input valid, input power_mod, output ready);
endinterface

`default_nettype wire

[sv/mexp_mulmod.sv]
`default_nettype none

module mexp_mulmod #(
  parameter int WIDTH = mexp_pkg::DEFAULT_WIDTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [WIDTH-1:0]     x,
  input  wire logic [WIDTH-1:0]     y,
  input  wire logic [WIDTH-1:0]     m,
  output logic [WIDTH-1:0]          result,
  output mexp_pkg::mm_status_t      status
);

  localparam int CW = $clog2(WIDTH);

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_DBL  = 2'd1;
  localparam logic [1:0] P_ADD  = 2'd2;

  logic [1:0]       phase;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] xr;
  logic [WIDTH-1:0] yr;
  logic [WIDTH-1:0] mr;
  logic [CW-1:0]    cnt;
  logic             done;

  logic [WIDTH-1:0] addend;
  logic [WIDTH:0]   sum;
  logic [WIDTH+1:0] diff;
  logic [WIDTH-1:0] acc_next;
  logic             step;

  // (acc + addend) mod m, both operands below m
  always_comb begin
    addend   = (phase == P_ADD) ? xr : acc;
    sum      = {1'b0, acc} + {1'b0, addend};
    diff     = {1'b0, sum} - {2'b00, mr};
    acc_next = diff[WIDTH+1] ? sum[WIDTH-1:0] : diff[WIDTH-1:0];
    step     = (phase == P_ADD) || ((phase == P_DBL) && !yr[WIDTH-1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        P_IDLE: begin
          if (start) begin
            acc   <= '0;
            xr    <= x;
            yr    <= y;
            mr    <= m;
            cnt   <= CW'(WIDTH - 1);
            phase <= P_DBL;
          end
        end
        P_DBL: begin
          acc <= acc_next;
          if (yr[WIDTH-1]) begin
            phase <= P_ADD;
          end
        end
        P_ADD: begin
          acc <= acc_next;
        end
        default: begin
          phase <= P_IDLE;
        end
      endcase
      if (step) begin
        if (cnt == '0) begin
          done  <= 1'b1;
          phase <= P_IDLE;
        end else begin
          cnt   <= cnt - 1'b1;
          yr    <= {yr[WIDTH-2:0], 1'b0};
          phase <= P_DBL;
        end
      end
    end
  end

  assign result      = acc;
  assign status.busy = (phase != P_IDLE);
  assign status.done = done;

endmodule

`default_nettype wire

[sv/modular_exponentiation.sv]
// one item at a time: square-and-multiply over all WIDTH exponent bits, left to right
// every modular multiply runs through one bit-serial unit, doubling for each bit of y and adding x for each set bit
// zero modulus skips the multiplier and gives a zero result
// next item accepted once the result is registered
// synchronous active-high reset: exponent 359, modulus 0, no result pending
`default_nettype none

module modular_exponentiation #(
  parameter int WIDTH = mexp_pkg::DEFAULT_WIDTH
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  mexp_in_if.sink                                   item_in,
  mexp_out_if.source                                item_out,
  input  wire logic                                 write_enable,
  input  wire logic [mexp_pkg::REG_INDEX_WIDTH-1:0] write_index,
  input  wire logic [WIDTH-1:0]                     write_data
);

  localparam int CW = $clog2(WIDTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_SQR  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]       state;
  logic [WIDTH-1:0] exponent;
  logic [WIDTH-1:0] modulus;
  logic [WIDTH-1:0] a_r;
  logic [WIDTH-1:0] exp_sr;
  logic [CW-1:0]    bit_cnt;
  logic [WIDTH-1:0] res;
  logic             mm_start;
  logic [WIDTH-1:0] mm_x;
  logic [WIDTH-1:0] mm_y;
  logic [WIDTH-1:0] mm_result;
  logic             out_valid;
  logic [WIDTH-1:0] out_data;
  logic             step;

  mexp_pkg::mm_status_t mm_stat;

  mexp_mulmod #(
    .WIDTH(WIDTH)
  ) u_mexp_mulmod (
    .clk    (clk),
    .rst    (rst),
    .start  (mm_start),
    .x      (mm_x),
    .y      (mm_y),
    .m      (modulus),
    .result (mm_result),
    .status (mm_stat)
  );

  assign item_in.ready     = (state == S_IDLE) && !mm_stat.busy;
  assign item_out.valid    = out_valid;
  assign item_out.power_mod = out_data;

  // one exponent bit finished
  assign step = mm_stat.done &&
                (((state == S_SQR) && !exp_sr[WIDTH-1]) || (state == S_MUL));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mm_start  <= 1'b0;
      out_valid <= 1'b0;
      exponent  <= WIDTH'(mexp_pkg::DEFAULT_EXPONENT);
      modulus   <= '0;
    end else begin
      mm_start <= 1'b0;
      if (write_enable) begin
        case (write_index)
          mexp_pkg::REG_EXPONENT: exponent <= write_data;
          mexp_pkg::REG_MODULUS:  modulus  <= write_data;
          default: ;
        endcase
      end
      if (out_valid && item_out.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_in.valid && item_in.ready) begin
            if (modulus == '0) begin
              res   <= '0;
              state <= S_DONE;
            end else begin
              // base mod m as 1 * base through the multiplier, 0 * base if m is 1
              mm_x     <= (modulus == WIDTH'(1)) ? '0 : WIDTH'(1);
              mm_y     <= item_in.base;
              mm_start <= 1'b1;
              state    <= S_RED;
            end
          end
        end
        S_RED: begin
          if (mm_stat.done) begin
            if (mm_result == '0) begin
              res   <= '0;
              state <= S_DONE;
            end else begin
              a_r      <= mm_result;
              exp_sr   <= exponent;
              bit_cnt  <= CW'(WIDTH - 1);
              mm_x     <= WIDTH'(1);
              mm_y     <= WIDTH'(1);
              mm_start <= 1'b1;
              state    <= S_SQR;
            end
          end
        end
        S_SQR: begin
          if (mm_stat.done && exp_sr[WIDTH-1]) begin
            mm_x     <= a_r;
            mm_y     <= mm_result;
            mm_start <= 1'b1;
            state    <= S_MUL;
          end
        end
        S_MUL: ;
        S_DONE: begin
          if (!out_valid || item_out.ready) begin
            out_valid <= 1'b1;
            out_data  <= res;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (step) begin
        if (bit_cnt == '0) begin
          res   <= mm_result;
          state <= S_DONE;
        end else begin
          bit_cnt  <= bit_cnt - CW'(1);
          exp_sr   <= {exp_sr[WIDTH-2:0], 1'b0};
          mm_x     <= mm_result;
          mm_y     <= mm_result;
          mm_start <= 1'b1;
          state    <= S_SQR;
        end
      end
    end
  end

endmodule

`default_nettype wire

[sv/mexp_checker.sv]
`default_nettype none

module mexp_checker #(
  parameter int WIDTH = mexp_pkg::DEFAULT_WIDTH
) (
  input wire logic                                 clk,
  input wire logic                                 rst,
  input wire logic                                 in_valid,
  input wire logic                                 in_ready,
  input wire logic                                 out_valid,
  input wire logic                                 out_ready,
  input wire logic [WIDTH-1:0]                     power_mod,
  input wire logic                                 write_enable,
  input wire logic [mexp_pkg::REG_INDEX_WIDTH-1:0] write_index,
  input wire logic [WIDTH-1:0]                     write_data
);

  logic [WIDTH-1:0] modulus;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= '0;
    end else if (write_enable && (write_index == mexp_pkg::REG_MODULUS)) begin
      modulus <= write_data;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(power_mod))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in flight");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result shown right after reset");

  a_below_modulus: assert property (@(posedge clk) disable iff (rst)
    out_valid && (modulus != '0) |-> (power_mod < modulus))
    else $error("result not reduced");

  a_zero_modulus: assert property (@(posedge clk) disable iff (rst)
    out_valid && (modulus == '0) |-> (power_mod == '0))
    else $error("nonzero result with zero modulus");

endmodule

bind modular_exponentiation mexp_checker #(
  .WIDTH(WIDTH)
) u_mexp_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (item_in.valid),
  .in_ready     (item_in.ready),
  .out_valid    (item_out.valid),
  .out_ready    (item_out.ready),
  .power_mod    (item_out.power_mod),
  .write_enable (write_enable),
  .write_index  (write_index),
  .write_data   (write_data)
);

`default_nettype wire
